FILE: rtl/core/dma_grant_lifecycle_table_defines.svh
// assertion macros for the dma grant table
`ifndef DMA_GRANT_LIFECYCLE_TABLE_DEFINES_SVH
`define DMA_GRANT_LIFECYCLE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define GDT_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("gdt: check failed");
`define GDT_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("gdt: check failed");
`else
`define GDT_ASSERT_IMP(lbl, pre, post)
`define GDT_ASSERT_NXT(lbl, pre, post)
`endif
`endif

FILE: rtl/core/gdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gdt_pkg;

    localparam int ENTRIES      = 256;
    localparam int ADDR_BITS    = 48;
    localparam int FIELD_ADDR_W = 48;
    // stored address width, addresses are kept masked to ADDR_BITS
    localparam int SAW = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
    localparam int ID_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int GID_W     = 16;
    localparam int RID_W     = 8;
    localparam int LEN_W     = 32;
    localparam int FLG_W     = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int LS_W      = 3;
    localparam int CMD_W     = 2;

    // free-slot search: groups of GRP entries, one registered level per group
    localparam int GRP       = 16;
    localparam int GRP_LOW_W = $clog2(GRP);
    localparam int NGRP      = (ENTRIES + GRP - 1) / GRP;
    localparam int PAD_W     = NGRP * GRP;

    // request queue between front and back
    localparam int QD     = 2;
    localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCNT_W = $clog2(QD + 1);

    localparam logic [MODE_W-1:0] MODE_CREATE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAP      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ACTIVATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REVOKE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DESTROY  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MAP_FAILED  = 3'd5;

    localparam logic [LS_W-1:0] LS_CREATED = 3'd0;
    localparam logic [LS_W-1:0] LS_MAPPED  = 3'd1;
    localparam logic [LS_W-1:0] LS_ACTIVE  = 3'd2;
    localparam logic [LS_W-1:0] LS_REVOKED = 3'd3;
    localparam logic [LS_W-1:0] LS_FAILED  = 3'd4;

    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd2;

    typedef struct packed {
        logic                    iommu_ok;
        logic [FLG_W-1:0]        map_flags;
        logic [LEN_W-1:0]        region_length;
        logic [FIELD_ADDR_W-1:0] phys_address;
        logic [FIELD_ADDR_W-1:0] io_address;
        logic [GID_W-1:0]        grant_id;
    } in_data_t;

    typedef struct packed {
        logic [FLG_W-1:0]        cmd_flags;
        logic [LEN_W-1:0]        cmd_length;
        logic [FIELD_ADDR_W-1:0] cmd_phys_address;
        logic [FIELD_ADDR_W-1:0] cmd_io_address;
        logic [CMD_W-1:0]        iommu_cmd;
        logic [LS_W-1:0]         entry_state;
        logic [RID_W-1:0]        result_id;
    } res_data_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        res_data_t           data;
    } result_t;

    typedef struct packed {
        logic [LS_W-1:0]  life;
        logic [SAW-1:0]   io;
        logic [SAW-1:0]   pa;
        logic [LEN_W-1:0] len;
        logic [FLG_W-1:0] flags;
    } row_t;

    // classified request as it travels through the queue
    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic              in_range;
        logic [ID_W-1:0]   id;
        logic [RID_W-1:0]  rid;
        logic [SAW-1:0]    io;
        logic [SAW-1:0]    pa;
        logic [LEN_W-1:0]  len;
        logic [FLG_W-1:0]  flags;
        logic              ok;
    } cmd_t;

    localparam int IN_DATA_W   = $bits(in_data_t);
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = $bits(res_data_t);
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

endpackage
`default_nettype wire

FILE: rtl/core/gdt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gdt_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gdt_pkg::MODE_W-1:0]     s_tuser,
    input  wire logic [gdt_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output gdt_pkg::cmd_t                       push_cmd
);
    import gdt_pkg::*;

    in_data_t d;

    assign d          = in_data_t'(s_tdata);
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_cmd = '0;
        case (s_tuser)
            MODE_CREATE, MODE_MAP, MODE_ACTIVATE,
            MODE_REVOKE, MODE_DESTROY, MODE_QUERY: push_cmd.op = s_tuser;
            default: push_cmd.op = MODE_BAD;
        endcase
        push_cmd.in_range = (32'(d.grant_id) < 32'(ENTRIES));
        push_cmd.id       = d.grant_id[ID_W-1:0];
        push_cmd.rid      = d.grant_id[RID_W-1:0];
        // addresses masked to the stored width here
        push_cmd.io       = d.io_address[SAW-1:0];
        push_cmd.pa       = d.phys_address[SAW-1:0];
        push_cmd.len      = d.region_length;
        push_cmd.flags    = d.map_flags;
        push_cmd.ok       = d.iommu_ok;
    end

endmodule
`default_nettype wire

FILE: rtl/core/gdt_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module gdt_cmd_queue (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push_valid,
    output logic                             push_ready,
    input  wire gdt_pkg::cmd_t               push_cmd,
    output logic                             pop_valid,
    input  wire logic                        pop_ready,
    output gdt_pkg::cmd_t                    pop_cmd,
    output logic [gdt_pkg::QCNT_W-1:0]       count
);
    import gdt_pkg::*;

    cmd_t               slot_reg [QD];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QD));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QD - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QD - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/gdt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gdt_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_data,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire gdt_pkg::cmd_t     q_cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gdt_pkg::result_t       out_res
);
    import gdt_pkg::*;

    localparam logic [0:0] ST_FETCH = 1'b0;
    localparam logic [0:0] ST_EXEC  = 1'b1;

    logic [0:0]          state_reg, state_next;
    logic [ENTRIES-1:0]  in_use_reg, in_use_next;
    logic                out_valid_reg, out_valid_next;
    logic                iommu_present_reg;
    cmd_t                cmd_reg;
    result_t             out_res_reg;
    row_t                mem [ENTRIES];
    row_t                rd_row_reg;

    logic [PAD_W-1:0]     free_pad;
    logic [NGRP-1:0]      grp_any_reg, grp_any_next;
    logic [GRP_LOW_W-1:0] grp_low_reg  [NGRP];
    logic [GRP_LOW_W-1:0] grp_low_next [NGRP];

    logic                found;
    logic [ID_W-1:0]     create_idx;
    logic                hit;
    logic                fire;
    logic                row_we, use_set, use_clr;
    logic [ID_W-1:0]     wr_addr;
    row_t                wr_row;
    result_t             res;
    logic [LS_W-1:0]     new_state;

    // level one of the free-slot search: lowest free entry of each group
    always_comb begin
        free_pad = '0;
        free_pad[ENTRIES-1:0] = ~in_use_reg;
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g] = |free_pad[g*GRP +: GRP];
            grp_low_next[g] = '0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (free_pad[g*GRP + b]) begin
                    grp_low_next[g] = GRP_LOW_W'(b);
                end
            end
        end
    end

    // level two: lowest group holding a free entry
    always_comb begin
        found      = 1'b0;
        create_idx = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                found      = 1'b1;
                create_idx = ID_W'(g*GRP + int'(grp_low_reg[g]));
            end
        end
    end

    assign q_pop = (state_reg == ST_FETCH) && q_valid;
    assign fire  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign hit   = cmd_reg.in_range && in_use_reg[cmd_reg.id];

    always_comb begin
        res       = '0;
        row_we    = 1'b0;
        use_set   = 1'b0;
        use_clr   = 1'b0;
        wr_addr   = cmd_reg.id;
        wr_row    = rd_row_reg;
        new_state = rd_row_reg.life;
        case (cmd_reg.op)
            MODE_CREATE: begin
                if (found) begin
                    wr_addr       = create_idx;
                    wr_row.life   = LS_CREATED;
                    wr_row.io     = cmd_reg.io;
                    wr_row.pa     = cmd_reg.pa;
                    wr_row.len    = cmd_reg.len;
                    wr_row.flags  = cmd_reg.flags;
                    row_we        = 1'b1;
                    use_set       = 1'b1;
                    res.data.result_id   = RID_W'(create_idx);
                    res.data.entry_state = LS_CREATED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            MODE_MAP, MODE_ACTIVATE, MODE_REVOKE, MODE_DESTROY, MODE_QUERY: begin
                res.data.result_id = cmd_reg.rid;
                if (!hit) begin
                    res.status = ST_INVALID;
                end else begin
                    case (cmd_reg.op)
                        MODE_MAP: begin
                            if (rd_row_reg.life != LS_CREATED) begin
                                res.status = ST_BAD_STATE;
                            end else if (iommu_present_reg) begin
                                res.data.iommu_cmd        = CMD_MAP;
                                res.data.cmd_io_address   = FIELD_ADDR_W'(rd_row_reg.io);
                                res.data.cmd_phys_address = FIELD_ADDR_W'(rd_row_reg.pa);
                                res.data.cmd_length       = rd_row_reg.len;
                                res.data.cmd_flags        = rd_row_reg.flags;
                                row_we = 1'b1;
                                if (cmd_reg.ok) begin
                                    new_state = LS_MAPPED;
                                end else begin
                                    new_state  = LS_FAILED;
                                    res.status = ST_MAP_FAILED;
                                end
                            end else if (rd_row_reg.pa == rd_row_reg.io) begin
                                row_we    = 1'b1;
                                new_state = LS_MAPPED;
                            end else begin
                                res.status = ST_UNSUPPORTED;
                            end
                        end
                        MODE_ACTIVATE: begin
                            if (rd_row_reg.life != LS_MAPPED) begin
                                res.status = ST_BAD_STATE;
                            end else begin
                                row_we    = 1'b1;
                                new_state = LS_ACTIVE;
                            end
                        end
                        MODE_REVOKE: begin
                            if (iommu_present_reg) begin
                                res.data.iommu_cmd      = CMD_UNMAP;
                                res.data.cmd_io_address = FIELD_ADDR_W'(rd_row_reg.io);
                                res.data.cmd_length     = rd_row_reg.len;
                            end
                            row_we    = 1'b1;
                            new_state = LS_REVOKED;
                        end
                        MODE_DESTROY: begin
                            if (rd_row_reg.life == LS_REVOKED ||
                                rd_row_reg.life == LS_CREATED ||
                                rd_row_reg.life == LS_FAILED) begin
                                use_clr = 1'b1;
                            end else begin
                                res.status = ST_BAD_STATE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    wr_row.life          = new_state;
                    res.data.entry_state = new_state;
                end
            end
            default: begin
                res.status = ST_UNSUPPORTED;
            end
        endcase
    end

    always_comb begin
        in_use_next = in_use_reg;
        if (fire && use_set) begin
            in_use_next[wr_addr] = 1'b1;
        end
        if (fire && use_clr) begin
            in_use_next[wr_addr] = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FETCH: begin
                if (q_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    state_next = ST_FETCH;
                end
            end
            default: state_next = ST_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_FETCH;
            in_use_reg        <= '0;
            out_valid_reg     <= 1'b0;
            iommu_present_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                iommu_present_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_any_reg <= grp_any_next;
        for (int g = 0; g < NGRP; g++) begin
            grp_low_reg[g] <= grp_low_next[g];
        end
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        if (fire) begin
            out_res_reg <= res;
        end
    end

    // entry store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (fire && row_we) begin
            mem[wr_addr] <= wr_row;
        end
        if (q_pop) begin
            rd_row_reg <= mem[q_cmd.id];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
`default_nettype wire

FILE: rtl/core/dma_grant_lifecycle_table.sv
// dma grant lifecycle table
// requests arrive on the s_ channel (operation code on s_tuser, grant id,
// region addresses, length, flags and the iommu outcome on s_tdata); each
// request gives exactly one result on the m_ channel (status on m_tuser,
// id, entry state and the iommu command with its fields on m_tdata)
// the iommu_present register is written through cfg_valid/cfg_data, always
// ready; the user must write it only while no request is in flight, which
// the block itself does not enforce
// a front stage decodes the request and range-checks the grant id, then
// pushes it into a two-deep queue; the back stage pops it and reads the
// entry row from the entry store into a register, then executes and writes
// back, and takes no new request until the current one is done, as set by
// the read-then-write of the entry store; the result sits in an output
// register, and while a result waits there with m_tready low the back
// holds its current request and the queue keeps taking requests until full
// reset clears the in-use map at once (no clearing pass), drops queued
// requests and any pending result, and sets iommu_present to 0
`timescale 1ns / 1ps
`default_nettype none
`include "dma_grant_lifecycle_table_defines.svh"
module dma_grant_lifecycle_table (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write: iommu_present
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_data,
    // request channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // mode
    input  wire logic [gdt_pkg::MODE_W-1:0]       s_tuser,
    // grant_id, io_address, phys_address, region_length, map_flags, iommu_ok
    input  wire logic [gdt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status
    output logic [gdt_pkg::STATUS_W-1:0]          m_tuser,
    // result_id, entry_state, iommu_cmd, cmd_io_address, cmd_phys_address,
    // cmd_length, cmd_flags
    output logic [gdt_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import gdt_pkg::*;

    // front to queue
    logic              push_valid, push_ready;
    cmd_t              push_cmd;
    // queue to back
    logic              q_valid, q_pop;
    cmd_t              q_cmd;
    logic [QCNT_W-1:0] q_count;
    // back result register
    result_t           out_res;

    // the register is a plain flop, every write is taken
    assign cfg_ready = 1'b1;

    gdt_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata[IN_DATA_W-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    gdt_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_cmd    (q_cmd),
        .count      (q_count)
    );

    gdt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = OUT_TDATA_W'(out_res.data);

    // an accepted request always lands in the queue
    `GDT_ASSERT_NXT(a_push_lands, s_tvalid && s_tready, q_count != '0)
    // no command means all command fields are zero
    `GDT_ASSERT_IMP(a_idle_cmd_zero, m_tvalid && out_res.data.iommu_cmd == CMD_NONE, out_res.data.cmd_io_address == '0 && out_res.data.cmd_phys_address == '0 && out_res.data.cmd_length == '0 && out_res.data.cmd_flags == '0)
    // a map command only comes with success or map failure
    `GDT_ASSERT_IMP(a_map_status, m_tvalid && out_res.data.iommu_cmd == CMD_MAP, out_res.status == ST_OK || out_res.status == ST_MAP_FAILED)
    // an unmap command only comes from a successful revoke
    `GDT_ASSERT_IMP(a_unmap_revoked, m_tvalid && out_res.data.iommu_cmd == CMD_UNMAP, out_res.status == ST_OK && out_res.data.entry_state == LS_REVOKED && out_res.data.cmd_phys_address == '0 && out_res.data.cmd_flags == '0)

endmodule
`default_nettype wire
